// ----- hdl/ors_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_pkg: shared types and codes for the 1-Wire ROM search block
// Item, result and search-state records, plus the mode and action codes.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int ROM_BITS = 64;
  localparam int POS_W    = 7;
  localparam int IDX_W    = 6;
  localparam int CRC_W    = 8;

  localparam logic [CRC_W-1:0] CRC_POLY_REFL = 8'h8C;

  // Mode codes of an input request.
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_PAIR  = 2'd2;

  // Action codes of a result.
  localparam logic [1:0] ACT_NONE       = 2'd0;
  localparam logic [1:0] ACT_SEARCH_CMD = 2'd1;
  localparam logic [1:0] ACT_WRITE_DIR  = 2'd2;

  localparam logic [POS_W-1:0] POS_FIRST = 7'd1;
  localparam logic [POS_W-1:0] POS_LAST  = 7'd64;
  localparam logic [POS_W-1:0] POS_DONE  = 7'd65;

  typedef struct packed {
    logic [1:0] mode;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } item_t;

  typedef struct packed {
    logic [1:0]          action;
    logic                direction;
    logic                finished;
    logic                found;
    logic [ROM_BITS-1:0] rom_code;
    logic                last_device;
  } result_t;

  typedef struct packed {
    logic [ROM_BITS-1:0] rom;
    logic [POS_W-1:0]    last_discrepancy;
    logic [POS_W-1:0]    last_zero_pos;
    logic [POS_W-1:0]    bit_position;
    logic [CRC_W-1:0]    crc;
    logic                device_done;
    logic                searching;
  } state_t;

endpackage

// ----- hdl/ors_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_step: search decision for one request
// Pure combinational step: from the current search state and one request it
// forms the result and the next search state.
// ----------------------------------------------------------------------------
module ors_step (
  input  ors_pkg::state_t  cur,
  input  ors_pkg::item_t   item,
  output ors_pkg::state_t  nxt,
  output ors_pkg::result_t res
);
  import ors_pkg::*;

  function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                               input logic b);
    logic [CRC_W-1:0] sh;
    sh = crc >> 1;
    return ((crc[0] ^ b) == 1'b1) ? (sh ^ CRC_POLY_REFL) : sh;
  endfunction

  logic [IDX_W-1:0] idx;
  logic             dir;
  logic             zero_pick;
  logic [ROM_BITS-1:0] rom_new;
  logic [CRC_W-1:0]    crc_new;

  assign idx = IDX_W'(cur.bit_position - POS_FIRST);

  always_comb begin
    zero_pick = 1'b0;
    if (item.id_bit != item.cmp_bit) begin
      dir = item.id_bit;
    end else if (cur.bit_position < cur.last_discrepancy) begin
      dir = cur.rom[idx];
      zero_pick = ~dir;
    end else begin
      dir = (cur.bit_position == cur.last_discrepancy);
      zero_pick = ~dir;
    end
    rom_new      = cur.rom;
    rom_new[idx] = dir;
    crc_new      = crc_bit(cur.crc, dir);
  end

  always_comb begin
    nxt = cur;
    res.action      = ACT_NONE;
    res.direction   = 1'b0;
    res.finished    = 1'b0;
    res.found       = 1'b0;
    res.last_device = 1'b0;
    case (item.mode)
      MODE_FIRST, MODE_NEXT: begin
        if (item.mode == MODE_FIRST) begin
          nxt.last_discrepancy = '0;
          nxt.device_done      = 1'b0;
        end
        nxt.searching = 1'b0;
        // A first search never sees the done flag, since it was just cleared.
        if ((item.mode == MODE_NEXT && cur.device_done) || !item.presence) begin
          nxt.last_discrepancy = '0;
          nxt.device_done      = 1'b0;
          res.finished         = 1'b1;
        end else begin
          res.action         = ACT_SEARCH_CMD;
          nxt.searching      = 1'b1;
          nxt.bit_position   = POS_FIRST;
          nxt.last_zero_pos  = '0;
          nxt.crc            = '0;
        end
      end
      MODE_PAIR: begin
        if (cur.searching) begin
          if (item.id_bit && item.cmp_bit) begin
            nxt.last_discrepancy = '0;
            nxt.device_done      = 1'b0;
            nxt.searching        = 1'b0;
            res.finished         = 1'b1;
          end else begin
            res.action    = ACT_WRITE_DIR;
            res.direction = dir;
            nxt.rom       = rom_new;
            nxt.crc       = crc_new;
            if (zero_pick) begin
              nxt.last_zero_pos = cur.bit_position;
            end
            if (cur.bit_position >= POS_LAST) begin
              res.finished     = 1'b1;
              nxt.searching    = 1'b0;
              nxt.bit_position = POS_DONE;
              if (crc_new == '0 && rom_new[7:0] != 8'd0) begin
                nxt.last_discrepancy = nxt.last_zero_pos;
                nxt.device_done      = (nxt.last_zero_pos == '0);
                res.found            = 1'b1;
                res.last_device      = (nxt.last_zero_pos == '0);
              end else begin
                nxt.last_discrepancy = '0;
                nxt.device_done      = 1'b0;
              end
            end else begin
              nxt.bit_position = cur.bit_position + POS_FIRST;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.rom_code = nxt.rom;
  end

endmodule

// ----- hdl/ors_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_state: search state registers
// Holds ROM, discrepancy marks, bit position, CRC and flags; updates them
// through the step logic whenever a request advances to the result stage.
// ----------------------------------------------------------------------------
module ors_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ors_pkg::item_t   item,
  output ors_pkg::result_t res,
  output ors_pkg::state_t  st
);
  import ors_pkg::*;

  state_t st_next;

  ors_step u_step (
    .cur  (st),
    .item (item),
    .nxt  (st_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.rom              <= '0;
      st.last_discrepancy <= '0;
      st.last_zero_pos    <= '0;
      st.bit_position     <= POS_FIRST;
      st.crc              <= '0;
      st.device_done      <= 1'b0;
      st.searching        <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

// ----- hdl/onewire_rom_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_rom_search: decision side of a 1-Wire master ROM search
// Turns begin and bit-pair requests into bus actions and tracks the ROM,
// discrepancy, CRC-8 and last-device state of the search.
//
//   channel   dir  tdata                                  tuser
//   s_axis    in   presence, id_bit, cmp_bit              mode
//   m_axis    out  direction, finished, found, rom_code,  action
//                  last_device
//
// A request is registered on entry and decided when its result loads the
// output register; one request per cycle is sustained while m_axis does not
// stall. The state update and the decision are made in the same cycle by the
// step logic. A stall on m_axis holds the result; one more request waits in
// the input register, and s_axis_tready drops only when both are full.
// Reset is synchronous and leaves the search idle with bit position one.
// ----------------------------------------------------------------------------
module onewire_rom_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // presence, id_bit, cmp_bit, zero fill
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // direction, finished, found,
                                      // rom_code[63:0], last_device, zero fill
  output logic [1:0]  m_axis_tuser    // action
);
  import ors_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t step_res;
  state_t  st;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.mode     <= s_axis_tuser;
      in_item.presence <= s_axis_tdata[0];
      in_item.id_bit   <= s_axis_tdata[1];
      in_item.cmp_bit  <= s_axis_tdata[2];
    end
  end

  ors_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .res     (step_res),
    .st      (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {4'd0, out_res.last_device, out_res.rom_code,
                          out_res.found, out_res.finished, out_res.direction};

  // A request waiting behind a stalled result stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("input register lost a waiting request");

  // A search command always restarts the pass at the first bit.
  a_begin_state: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.action == ACT_SEARCH_CMD |=>
      st.searching && st.bit_position == POS_FIRST && st.crc == '0)
    else $error("search command without a fresh search state");

  // A finished pass leaves the search idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.finished |=> !st.searching)
    else $error("search still running after a finished pass");

  // The last-device mark comes only with a found ROM.
  a_last_found: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.last_device |-> step_res.found && step_res.finished)
    else $error("last device reported without a found ROM");

endmodule
